### hdl/tlr_pkg.sv
// shared widths, codes and command/status types of the triangle lightmap rasterizer
// no dependencies
package tlr_pkg;

    localparam int CW   = 21;   // vertex coordinate, 8 fraction bits
    localparam int DFW  = 22;   // vertex difference
    localparam int EDW  = 23;   // oriented edge constant, pixel offset
    localparam int XW   = 15;   // bounding box bound, signed
    localparam int PW   = 13;   // pixel column and row
    localparam int RGW  = 13;   // config register width
    localparam int EW   = 49;   // edge function value
    localparam int DW   = 46;   // denominator and remainder
    localparam int NW   = 68;   // division numerator and quotient
    localparam int IDW  = 32;
    localparam int AW   = 28;
    localparam int BW   = 18;
    localparam int LW   = 4;
    localparam int TW   = 9;
    localparam int WHW  = 26;   // width times height
    localparam int CFG_IW = 2;

    localparam int MAX_ATLAS_SIZE_DEF = 4096;
    localparam int TILE_SIZE_DEF      = 8;
    localparam int MAX_LAYERS_DEF     = 16;

    localparam logic [CFG_IW-1:0] REG_ATLAS_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_ATLAS_HEIGHT = 2'd1;
    localparam logic [RGW-1:0]    ATLAS_RESET      = 13'd1024;

    localparam int BARY_MAX = 131071;
    localparam int BARY_MIN = -131072;
    localparam int FRAC_SH  = 17;   // two times Q2.16 scale
    localparam int STEP_SH  = 25;   // one pixel step times the scale

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP_A,
        ST_SETUP_B,
        ST_SETUP_C,
        ST_SETUP_D,
        ST_SETUP_E,
        ST_SETUP_F,
        ST_SETUP_G,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_PIX_A,
        ST_PIX_B,
        ST_FLUSH
    } state_t;

    typedef enum logic [2:0] {
        JOB_UC,
        JOB_VC,
        JOB_UA,
        JOB_UB,
        JOB_VA,
        JOB_VB
    } job_t;

    localparam job_t JOB_LAST = JOB_VB;

    typedef struct packed {
        logic load;
        logic setup_a;
        logic setup_b;
        logic setup_c;
        logic setup_d;
        logic setup_e;
        logic setup_f;
        logic setup_g;
        logic div_go;
        logic div_wait;
        job_t job;
        logic pix_eval;
        logic pix_step;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic div_done;
        logic pix_ok;
        logic pix_end;
        logic flush_ok;
    } status_t;

endpackage

### hdl/tlr_div.sv
// restoring serial divider, floor quotient and nonnegative remainder, one bit per cycle
// depends on tlr_pkg
module tlr_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [tlr_pkg::NW-1:0] num,
    input  logic        [tlr_pkg::DW-1:0] den,
    output logic                          done,
    output logic signed [tlr_pkg::NW-1:0] quo,
    output logic        [tlr_pkg::DW-1:0] rem
);
    import tlr_pkg::*;

    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [NW-1:0]    dvd_reg;
    logic [DW-1:0]    acc_reg;
    logic [DW-1:0]    den_reg;
    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             ge;

    always_comb begin
        trial = {acc_reg, dvd_reg[NW-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // negative numerator divides its complement, then maps back
    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= num[NW-1];
            dvd_reg <= num[NW-1] ? ~num : num;
            acc_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            acc_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            dvd_reg <= {dvd_reg[NW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? $signed(~dvd_reg) : $signed(dvd_reg);
    assign rem  = neg_reg ? (den_reg - 1'b1 - acc_reg) : acc_reg;

endmodule

### hdl/tlr_ctrl.sv
// controller state machine: setup sequence, division jobs, pixel walk and flush
// depends on tlr_pkg
module tlr_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  tlr_pkg::status_t status,
    output tlr_pkg::cmd_t    cmd
);
    import tlr_pkg::*;

    state_t state_reg, state_next;
    job_t   job_reg, job_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            job_reg   <= JOB_UC;
        end else begin
            state_reg <= state_next;
            job_reg   <= job_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        case (state_reg)
            ST_IDLE:    if (s_valid) state_next = ST_SETUP_A;
            ST_SETUP_A: state_next = ST_SETUP_B;
            ST_SETUP_B: state_next = ST_SETUP_C;
            ST_SETUP_C: state_next = ST_SETUP_D;
            ST_SETUP_D: state_next = status.empty ? ST_IDLE : ST_SETUP_E;
            ST_SETUP_E: state_next = ST_SETUP_F;
            ST_SETUP_F: state_next = ST_SETUP_G;
            ST_SETUP_G: begin
                state_next = ST_DIV_GO;
                job_next   = JOB_UC;
            end
            ST_DIV_GO:  state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (status.div_done) begin
                    if (job_reg == JOB_LAST) begin
                        state_next = ST_PIX_A;
                    end else begin
                        state_next = ST_DIV_GO;
                        job_next   = job_t'(job_reg + 3'd1);
                    end
                end
            end
            ST_PIX_A:   state_next = ST_PIX_B;
            ST_PIX_B: begin
                if (status.pix_ok) state_next = status.pix_end ? ST_FLUSH : ST_PIX_A;
            end
            ST_FLUSH:   if (status.flush_ok) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        cmd.job = job_reg;
        case (state_reg)
            ST_IDLE:     cmd.load     = s_valid;
            ST_SETUP_A:  cmd.setup_a  = 1'b1;
            ST_SETUP_B:  cmd.setup_b  = 1'b1;
            ST_SETUP_C:  cmd.setup_c  = 1'b1;
            ST_SETUP_D:  cmd.setup_d  = 1'b1;
            ST_SETUP_E:  cmd.setup_e  = 1'b1;
            ST_SETUP_F:  cmd.setup_f  = 1'b1;
            ST_SETUP_G:  cmd.setup_g  = 1'b1;
            ST_DIV_GO:   cmd.div_go   = 1'b1;
            ST_DIV_WAIT: cmd.div_wait = 1'b1;
            ST_PIX_A:    cmd.pix_eval = 1'b1;
            ST_PIX_B:    cmd.pix_step = status.pix_ok;
            ST_FLUSH:    cmd.flush    = status.flush_ok;
            default:     cmd.load     = 1'b0;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

### hdl/tlr_datapath.sv
// datapath: triangle setup, incremental edge and barycentric tracking, coverage test,
// held result and output register; depends on tlr_pkg and tlr_div
module tlr_datapath #(
    parameter int MAX_ATLAS_SIZE = tlr_pkg::MAX_ATLAS_SIZE_DEF,
    parameter int TILE_SIZE      = tlr_pkg::TILE_SIZE_DEF,
    parameter int MAX_LAYERS     = tlr_pkg::MAX_LAYERS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tlr_pkg::cmd_t                  cmd,
    output tlr_pkg::status_t               status,
    input  logic                           cfg_wr_en,
    input  logic [tlr_pkg::CFG_IW-1:0]     cfg_wr_index,
    input  logic [tlr_pkg::RGW-1:0]        cfg_wr_data,
    input  logic signed [tlr_pkg::CW-1:0]  s_vert0_x,
    input  logic signed [tlr_pkg::CW-1:0]  s_vert0_y,
    input  logic signed [tlr_pkg::CW-1:0]  s_vert1_x,
    input  logic signed [tlr_pkg::CW-1:0]  s_vert1_y,
    input  logic signed [tlr_pkg::CW-1:0]  s_vert2_x,
    input  logic signed [tlr_pkg::CW-1:0]  s_vert2_y,
    input  logic [tlr_pkg::IDW-1:0]        s_instance_id,
    input  logic [tlr_pkg::IDW-1:0]        s_primitive_id,
    input  logic [tlr_pkg::LW-1:0]         s_layer_index,
    input  logic [tlr_pkg::TW-1:0]         s_tile_col,
    input  logic [tlr_pkg::TW-1:0]         s_tile_row,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [tlr_pkg::AW-1:0]         m_write_address,
    output logic [tlr_pkg::IDW-1:0]        m_out_instance,
    output logic [tlr_pkg::IDW-1:0]        m_out_primitive,
    output logic signed [tlr_pkg::BW-1:0]  m_bary_u,
    output logic signed [tlr_pkg::BW-1:0]  m_bary_v,
    output logic                           m_last_write
);
    import tlr_pkg::*;

    localparam logic [XW-1:0] MAXA  = XW'(MAX_ATLAS_SIZE);
    localparam logic [XW-1:0] TS    = XW'(TILE_SIZE);
    localparam logic [8:0]    MAXL  = 9'(MAX_LAYERS);

    typedef struct packed {
        logic signed [NW-1:0] q;
        logic [DW-1:0]        r;
    } qr_t;

    function automatic qr_t qr_add(input qr_t a, input qr_t k, input logic [DW-1:0] den2);
        qr_t       res;
        logic [DW:0] s;
        s = {1'b0, a.r} + {1'b0, k.r};
        if (s >= {1'b0, den2}) begin
            res.r = DW'(s - {1'b0, den2});
            res.q = a.q + k.q + NW'(1);
        end else begin
            res.r = s[DW-1:0];
            res.q = a.q + k.q;
        end
        return res;
    endfunction

    function automatic logic signed [BW-1:0] sat(input logic signed [NW-1:0] q);
        if (q > BARY_MAX)      return BW'(BARY_MAX);
        else if (q < BARY_MIN) return BW'(BARY_MIN);
        else                   return q[BW-1:0];
    endfunction

    function automatic logic signed [XW-1:0] smax(input logic signed [XW-1:0] a,
                                                 input logic signed [XW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [XW-1:0] smin(input logic signed [XW-1:0] a,
                                                 input logic signed [XW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // config registers
    logic [RGW-1:0] width_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= ATLAS_RESET;
            height_reg <= ATLAS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_ATLAS_WIDTH:  width_reg  <= cfg_wr_data;
                REG_ATLAS_HEIGHT: height_reg <= cfg_wr_data;
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // captured word
    logic signed [CW-1:0] x0_reg, y0_reg, x1_reg, y1_reg, x2_reg, y2_reg;
    logic [IDW-1:0]       inst_reg, prim_reg;
    logic [LW-1:0]        layer_reg;
    logic [TW-1:0]        tcol_reg, trow_reg;

    // setup registers
    logic signed [DFW-1:0]   e0x_reg, e0y_reg, e1x_reg, e1y_reg;
    logic signed [XW-1:0]    xlo_reg, xhi_reg, ylo_reg, yhi_reg;
    logic [RGW-1:0]          w_reg, h_reg;
    logic                    empty_reg;
    logic signed [2*DFW-1:0] p1_reg, p2_reg;
    logic [WHW-1:0]          wh_reg;
    logic signed [EDW-1:0]   qx0_reg, qy0_reg;
    logic [DW-1:0]           d_reg;
    logic signed [EDW-1:0]   av_reg, bv_reg, aw_reg, bw_reg;
    logic signed [EDW:0]     au_reg, bu_reg;
    logic [AW-1:0]           lwh_reg;
    logic signed [2*EDW-1:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [EW-1:0]    v0_reg, w0_reg, vc_reg, wc_reg, uc_reg;

    // walk registers
    logic [PW-1:0]           m_reg, n_reg;
    logic signed [EW-1:0]    v_reg, w_reg_e, vrow_reg, wrow_reg;
    qr_t                     qu_reg, qv_reg, qurow_reg, qvrow_reg;
    qr_t                     kua_reg, kub_reg, kva_reg, kvb_reg;
    logic signed [EW-1:0]    vv_reg [5];
    logic signed [EW-1:0]    ww_reg [5];
    logic [WHW-1:0]          nw_reg;

    // held and output words
    logic                    held_valid_reg;
    logic [AW-1:0]           held_addr_reg;
    logic signed [BW-1:0]    held_u_reg, held_v_reg;
    logic                    out_valid_reg;
    logic [AW-1:0]           out_addr_reg;
    logic [IDW-1:0]          out_inst_reg, out_prim_reg;
    logic signed [BW-1:0]    out_u_reg, out_v_reg;
    logic                    out_last_reg;

    // setup a combinational
    logic signed [CW-1:0]   mnx, mny, mxx, mxy;
    logic signed [CW:0]     mxx_c, mxy_c;
    logic signed [CW-1:0]   mnx_f, mny_f;
    logic signed [CW:0]     mxx_f, mxy_f;
    logic signed [XW-1:0]   tc8, tr8, xlo_a, xhi_a, ylo_a, yhi_a;
    logic [RGW-1:0]         w_eff, h_eff;
    logic                   empty_a;

    always_comb begin
        mnx = (x0_reg < x1_reg) ? x0_reg : x1_reg;
        if (x2_reg < mnx) mnx = x2_reg;
        mny = (y0_reg < y1_reg) ? y0_reg : y1_reg;
        if (y2_reg < mny) mny = y2_reg;
        mxx = (x0_reg > x1_reg) ? x0_reg : x1_reg;
        if (x2_reg > mxx) mxx = x2_reg;
        mxy = (y0_reg > y1_reg) ? y0_reg : y1_reg;
        if (y2_reg > mxy) mxy = y2_reg;
        mnx_f = mnx >>> 8;
        mny_f = mny >>> 8;
        mxx_c = (CW+1)'(mxx) + (CW+1)'(255);
        mxy_c = (CW+1)'(mxy) + (CW+1)'(255);
        mxx_f = mxx_c >>> 8;
        mxy_f = mxy_c >>> 8;
        tc8   = $signed(XW'(tcol_reg) * TS);
        tr8   = $signed(XW'(trow_reg) * TS);
        w_eff = (XW'(width_reg) > MAXA) ? RGW'(MAXA) : width_reg;
        h_eff = (XW'(height_reg) > MAXA) ? RGW'(MAXA) : height_reg;
        xlo_a = smax(mnx_f[XW-1:0], tc8);
        ylo_a = smax(mny_f[XW-1:0], tr8);
        xhi_a = smin(smin(mxx_f[XW-1:0], tc8 + $signed(TS)), $signed(XW'(w_eff)));
        yhi_a = smin(smin(mxy_f[XW-1:0], tr8 + $signed(TS)), $signed(XW'(h_eff)));
        empty_a = (xlo_a >= xhi_a) || (ylo_a >= yhi_a) || ({5'd0, layer_reg} >= MAXL);
    end

    // setup c combinational
    logic signed [2*DFW:0] den_c;
    logic                  neg_c;

    always_comb begin
        den_c = (2*DFW+1)'(p1_reg) - (2*DFW+1)'(p2_reg);
        neg_c = den_c[2*DFW];
    end

    // shifted edge constants
    logic signed [EW-1:0] av7, bv7, aw7, bw7, av8, bv8, aw8, bw8;
    logic signed [EW-1:0] d_ew;

    always_comb begin
        av7  = EW'(av_reg) <<< 7;
        bv7  = EW'(bv_reg) <<< 7;
        aw7  = EW'(aw_reg) <<< 7;
        bw7  = EW'(bw_reg) <<< 7;
        av8  = EW'(av_reg) <<< 8;
        bv8  = EW'(bv_reg) <<< 8;
        aw8  = EW'(aw_reg) <<< 8;
        bw8  = EW'(bw_reg) <<< 8;
        d_ew = $signed(EW'(d_reg));
    end

    // division jobs
    logic                 div_done;
    logic signed [NW-1:0] div_num, div_quo;
    logic [DW-1:0]        div_den, div_rem;
    qr_t                  div_res;

    always_comb begin
        case (cmd.job)
            JOB_UC:  div_num = (NW'(uc_reg) <<< FRAC_SH) + $signed(NW'(d_reg));
            JOB_VC:  div_num = (NW'(vc_reg) <<< FRAC_SH) + $signed(NW'(d_reg));
            JOB_UA:  div_num = NW'(au_reg) <<< STEP_SH;
            JOB_UB:  div_num = NW'(bu_reg) <<< STEP_SH;
            JOB_VA:  div_num = NW'(av_reg) <<< STEP_SH;
            JOB_VB:  div_num = NW'(bv_reg) <<< STEP_SH;
            default: div_num = '0;
        endcase
        div_den   = d_reg << 1;
        div_res.q = div_quo;
        div_res.r = div_rem;
    end

    tlr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_go),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    // coverage test of the evaluated points
    logic signed [EW-1:0] uu [5];
    logic [4:0]           in_tri;
    logic                 hit;
    logic                 out_free;
    logic                 step_x, step_y;
    logic [AW-1:0]        addr_now;

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            uu[i]     = d_ew - vv_reg[i] - ww_reg[i];
            in_tri[i] = !uu[i][EW-1] && (uu[i] <= d_ew) &&
                        !vv_reg[i][EW-1] && (vv_reg[i] <= d_ew) &&
                        !ww_reg[i][EW-1] && (ww_reg[i] <= d_ew);
        end
        hit      = |in_tri;
        out_free = !out_valid_reg || m_ready;
        step_x   = ($signed(XW'(m_reg)) + $signed(XW'(1))) < xhi_reg;
        step_y   = ($signed(XW'(n_reg)) + $signed(XW'(1))) < yhi_reg;
        addr_now = lwh_reg + AW'(nw_reg) + AW'(m_reg);
    end

    assign status.empty    = empty_reg;
    assign status.div_done = div_done;
    assign status.pix_ok   = !(hit && held_valid_reg) || out_free;
    assign status.pix_end  = !step_x && !step_y;
    assign status.flush_ok = !held_valid_reg || out_free;

    // setup and walk datapath
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x0_reg    <= s_vert0_x;
            y0_reg    <= s_vert0_y;
            x1_reg    <= s_vert1_x;
            y1_reg    <= s_vert1_y;
            x2_reg    <= s_vert2_x;
            y2_reg    <= s_vert2_y;
            inst_reg  <= s_instance_id;
            prim_reg  <= s_primitive_id;
            layer_reg <= s_layer_index;
            tcol_reg  <= s_tile_col;
            trow_reg  <= s_tile_row;
        end
        if (cmd.setup_a) begin
            e0x_reg   <= DFW'(x1_reg) - DFW'(x0_reg);
            e0y_reg   <= DFW'(y1_reg) - DFW'(y0_reg);
            e1x_reg   <= DFW'(x2_reg) - DFW'(x0_reg);
            e1y_reg   <= DFW'(y2_reg) - DFW'(y0_reg);
            xlo_reg   <= xlo_a;
            xhi_reg   <= xhi_a;
            ylo_reg   <= ylo_a;
            yhi_reg   <= yhi_a;
            w_reg     <= w_eff;
            h_reg     <= h_eff;
            empty_reg <= empty_a;
        end
        if (cmd.setup_b) begin
            p1_reg  <= e0x_reg * e1y_reg;
            p2_reg  <= e0y_reg * e1x_reg;
            wh_reg  <= w_reg * h_reg;
            qx0_reg <= $signed({xlo_reg, 8'd0}) - EDW'(x0_reg);
            qy0_reg <= $signed({ylo_reg, 8'd0}) - EDW'(y0_reg);
        end
        if (cmd.setup_c) begin
            d_reg     <= DW'(neg_c ? -den_c : den_c);
            empty_reg <= empty_reg || (den_c == '0);
            av_reg    <= neg_c ? -EDW'(e1y_reg) :  EDW'(e1y_reg);
            bv_reg    <= neg_c ?  EDW'(e1x_reg) : -EDW'(e1x_reg);
            aw_reg    <= neg_c ?  EDW'(e0y_reg) : -EDW'(e0y_reg);
            bw_reg    <= neg_c ? -EDW'(e0x_reg) :  EDW'(e0x_reg);
            lwh_reg   <= AW'(layer_reg) * AW'(wh_reg);
        end
        if (cmd.setup_d) begin
            m1_reg <= qx0_reg * av_reg;
            m2_reg <= qy0_reg * bv_reg;
            m3_reg <= qx0_reg * aw_reg;
            m4_reg <= qy0_reg * bw_reg;
        end
        if (cmd.setup_e) begin
            v0_reg <= EW'(m1_reg) + EW'(m2_reg);
            w0_reg <= EW'(m3_reg) + EW'(m4_reg);
        end
        if (cmd.setup_f) begin
            vc_reg   <= v0_reg + av7 + bv7;
            wc_reg   <= w0_reg + aw7 + bw7;
            au_reg   <= -((EDW+1)'(av_reg) + (EDW+1)'(aw_reg));
            bu_reg   <= -((EDW+1)'(bv_reg) + (EDW+1)'(bw_reg));
            v_reg    <= v0_reg;
            w_reg_e  <= w0_reg;
            vrow_reg <= v0_reg;
            wrow_reg <= w0_reg;
            m_reg    <= xlo_reg[PW-1:0];
            n_reg    <= ylo_reg[PW-1:0];
        end
        if (cmd.setup_g) begin
            uc_reg <= d_ew - vc_reg - wc_reg;
        end
        if (cmd.div_wait && div_done) begin
            case (cmd.job)
                JOB_UC: begin
                    qu_reg    <= div_res;
                    qurow_reg <= div_res;
                end
                JOB_VC: begin
                    qv_reg    <= div_res;
                    qvrow_reg <= div_res;
                end
                JOB_UA:  kua_reg <= div_res;
                JOB_UB:  kub_reg <= div_res;
                JOB_VA:  kva_reg <= div_res;
                JOB_VB:  kvb_reg <= div_res;
                default: kvb_reg <= kvb_reg;
            endcase
        end
        if (cmd.pix_eval) begin
            vv_reg[0] <= v_reg + av7 + bv7;
            vv_reg[1] <= v_reg;
            vv_reg[2] <= v_reg + bv8;
            vv_reg[3] <= v_reg + av8;
            vv_reg[4] <= v_reg + av8 + bv8;
            ww_reg[0] <= w_reg_e + aw7 + bw7;
            ww_reg[1] <= w_reg_e;
            ww_reg[2] <= w_reg_e + bw8;
            ww_reg[3] <= w_reg_e + aw8;
            ww_reg[4] <= w_reg_e + aw8 + bw8;
            nw_reg    <= n_reg * w_reg;
        end
        if (cmd.pix_step) begin
            if (hit) begin
                held_addr_reg <= addr_now;
                held_u_reg    <= sat(qu_reg.q);
                held_v_reg    <= sat(qv_reg.q);
            end
            if (step_x) begin
                m_reg   <= m_reg + 1'b1;
                v_reg   <= v_reg + av8;
                w_reg_e <= w_reg_e + aw8;
                qu_reg  <= qr_add(qu_reg, kua_reg, div_den);
                qv_reg  <= qr_add(qv_reg, kva_reg, div_den);
            end else if (step_y) begin
                m_reg     <= xlo_reg[PW-1:0];
                n_reg     <= n_reg + 1'b1;
                v_reg     <= vrow_reg + bv8;
                w_reg_e   <= wrow_reg + bw8;
                vrow_reg  <= vrow_reg + bv8;
                wrow_reg  <= wrow_reg + bw8;
                qu_reg    <= qr_add(qurow_reg, kub_reg, div_den);
                qv_reg    <= qr_add(qvrow_reg, kvb_reg, div_den);
                qurow_reg <= qr_add(qurow_reg, kub_reg, div_den);
                qvrow_reg <= qr_add(qvrow_reg, kvb_reg, div_den);
            end
        end
    end

    // held word moves to the output register when the next hit or the flush comes
    logic push;

    assign push = held_valid_reg && ((cmd.pix_step && hit) || cmd.flush);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.flush) held_valid_reg <= 1'b0;
            else if (cmd.pix_step && hit) held_valid_reg <= 1'b1;
            out_valid_reg <= push || (out_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            out_addr_reg <= held_addr_reg;
            out_inst_reg <= inst_reg;
            out_prim_reg <= prim_reg;
            out_u_reg    <= held_u_reg;
            out_v_reg    <= held_v_reg;
            out_last_reg <= cmd.flush;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_write_address = out_addr_reg;
    assign m_out_instance  = out_inst_reg;
    assign m_out_primitive = out_prim_reg;
    assign m_bary_u        = out_u_reg;
    assign m_bary_v        = out_v_reg;
    assign m_last_write    = out_last_reg;

endmodule

### hdl/triangle_lightmap_rasterizer_core.sv
// top level of the conservative triangle lightmap rasterizer
// depends on tlr_pkg, tlr_ctrl, tlr_datapath (and through it tlr_div)
//
// usage:
//   s_ channel takes one triangle word: three Q.8 vertices, ids, layer and an 8x8 tile.
//   m_ channel gives one word per covered pixel of that tile, row by row, left to right,
//   with the atlas write address, the ids and the saturated Q2.16 centre barycentrics;
//   m_last_write marks the final word of a triangle. A triangle that covers nothing
//   gives no word at all.
//   cfg_wr_en writes atlas_width (index 0) or atlas_height (index 1) at once; write only
//   while the block is idle.
//   sequence: setup states ST_SETUP_A to ST_SETUP_G, then six serial divisions of the shared
//   divider (one quotient bit per cycle over 68 bits), then an evaluate state and a step
//   state per visited pixel and a flush state; the step and the flush wait while the
//   output is stalled. A degenerate or empty triangle leaves after setup state D. One
//   triangle is in work at a time; s_ready is high only when idle.
//   each covered pixel is held one step so the last one can be marked; an output
//   register parts the block from the receiver, and a stall holds the pixel walk.
//   reset (aresetn low, synchronous) empties the block and sets both sizes to 1024.
module triangle_lightmap_rasterizer_core #(
    parameter int MAX_ATLAS_SIZE = tlr_pkg::MAX_ATLAS_SIZE_DEF,
    parameter int TILE_SIZE      = tlr_pkg::TILE_SIZE_DEF,
    parameter int MAX_LAYERS     = tlr_pkg::MAX_LAYERS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [tlr_pkg::CFG_IW-1:0]     cfg_wr_index,
    input  logic [tlr_pkg::RGW-1:0]        cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [tlr_pkg::CW-1:0]  s_vert0_x,
    input  logic signed [tlr_pkg::CW-1:0]  s_vert0_y,
    input  logic signed [tlr_pkg::CW-1:0]  s_vert1_x,
    input  logic signed [tlr_pkg::CW-1:0]  s_vert1_y,
    input  logic signed [tlr_pkg::CW-1:0]  s_vert2_x,
    input  logic signed [tlr_pkg::CW-1:0]  s_vert2_y,
    input  logic [tlr_pkg::IDW-1:0]        s_instance_id,
    input  logic [tlr_pkg::IDW-1:0]        s_primitive_id,
    input  logic [tlr_pkg::LW-1:0]         s_layer_index,
    input  logic [tlr_pkg::TW-1:0]         s_tile_col,
    input  logic [tlr_pkg::TW-1:0]         s_tile_row,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [tlr_pkg::AW-1:0]         m_write_address,
    output logic [tlr_pkg::IDW-1:0]        m_out_instance,
    output logic [tlr_pkg::IDW-1:0]        m_out_primitive,
    output logic signed [tlr_pkg::BW-1:0]  m_bary_u,
    output logic signed [tlr_pkg::BW-1:0]  m_bary_v,
    output logic                           m_last_write
);
    import tlr_pkg::*;

    cmd_t    cmd;
    status_t status;

    tlr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tlr_datapath #(
        .MAX_ATLAS_SIZE (MAX_ATLAS_SIZE),
        .TILE_SIZE      (TILE_SIZE),
        .MAX_LAYERS     (MAX_LAYERS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_index    (cfg_wr_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_vert0_x       (s_vert0_x),
        .s_vert0_y       (s_vert0_y),
        .s_vert1_x       (s_vert1_x),
        .s_vert1_y       (s_vert1_y),
        .s_vert2_x       (s_vert2_x),
        .s_vert2_y       (s_vert2_y),
        .s_instance_id   (s_instance_id),
        .s_primitive_id  (s_primitive_id),
        .s_layer_index   (s_layer_index),
        .s_tile_col      (s_tile_col),
        .s_tile_row      (s_tile_row),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_write_address (m_write_address),
        .m_out_instance  (m_out_instance),
        .m_out_primitive (m_out_primitive),
        .m_bary_u        (m_bary_u),
        .m_bary_v        (m_bary_v),
        .m_last_write    (m_last_write)
    );

endmodule

### hdl/tlr_checker.sv
// port-level checks of the rasterizer core, bound to the top level
// depends on triangle_lightmap_rasterizer_core
module tlr_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready
);

    // result word stays offered until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result word dropped before it was taken");

    // one triangle at a time: busy right after a word is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken again while a triangle is in setup");

    // no result can appear in the first cycle of setup
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result word appeared during setup");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

endmodule

bind triangle_lightmap_rasterizer_core tlr_checker u_tlr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready)
);
